FILE: rtl/assert_macros.svh
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock, disabled during reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/pho_pkg.sv
// ----------------------------------------------------------------------------
// pho_pkg
// types and constants for the planar odometry block
// ----------------------------------------------------------------------------
package pho_pkg;

   localparam int CordicSteps = 30;
   localparam logic signed [33:0] CordicGain = 34'sd652032874;
   localparam logic [31:0] InvTwoPi = 32'd683565276;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ANG_LO,
      ST_ANG_HI,
      ST_ANG_ADD,
      ST_COR_START,
      ST_COR_RUN,
      ST_COR_DONE,
      ST_MUL,
      ST_VEL,
      ST_POS_MUL,
      ST_POS_ADD,
      ST_OUT
   } state_type;

   function automatic logic [31:0] arc_lookup(input logic [4:0] idx);
      logic [31:0] r;
      begin
         unique case (idx)
            5'd0: r = 32'h20000000;  5'd1: r = 32'h12E4051E;
            5'd2: r = 32'h09FB385B;  5'd3: r = 32'h051111D4;
            5'd4: r = 32'h028B0D43;  5'd5: r = 32'h0145D7E1;
            5'd6: r = 32'h00A2F61E;  5'd7: r = 32'h00517C55;
            5'd8: r = 32'h0028BE53;  5'd9: r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A; 5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
            default: r = 32'h0;
         endcase
         return r;
      end
   endfunction

endpackage

FILE: rtl/planar_holonomic_odometry.sv
// ----------------------------------------------------------------------------
// planar_holonomic_odometry
// dead-reckoning odometry: heading step, cordic rotation, position integration
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  req_    | in        | req_valid/stall   | body velocity, yaw rate, dt
//  rsp_    | out       | rsp_valid/stall   | pose, world velocity, quaternion
//
// after acceptance the block runs 3 heading steps, a cordic pass, 4 velocity
// and 4 position steps and a second cordic pass before the result is valid.
// reset (synchronous) zeroes heading and position and empties the output.
// req_stall is high from acceptance until the result has been taken.
module planar_holonomic_odometry #(
   parameter int POS_BITS = 48
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [31:0]         req_body_vel_x,
   input  logic signed [31:0]         req_body_vel_y,
   input  logic signed [31:0]         req_yaw_rate,
   input  logic [15:0]                req_elapsed_time,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [POS_BITS-1:0] rsp_world_pos_x,
   output logic signed [POS_BITS-1:0] rsp_world_pos_y,
   output logic [31:0]                rsp_heading_angle,
   output logic signed [31:0]         rsp_world_vel_x,
   output logic signed [31:0]         rsp_world_vel_y,
   output logic signed [31:0]         rsp_yaw_rate_out,
   output logic signed [31:0]         rsp_quat_z,
   output logic signed [31:0]         rsp_quat_w
);
   import pho_pkg::*;

   localparam logic signed [POS_BITS-1:0] PosMax = {1'b0, {(POS_BITS-1){1'b1}}};
   localparam logic signed [POS_BITS-1:0] PosMin = {1'b1, {(POS_BITS-1){1'b0}}};

   state_type state_ff, state_in;

   logic signed [31:0] vx_ff, vy_ff, wz_ff;
   logic [15:0] dt_ff;
   logic [31:0] heading_ff;
   logic signed [POS_BITS-1:0] posx_ff, posy_ff;
   logic [47:0] mag_ff;
   logic [63:0] acc_ff;
   logic signed [33:0] cx_ff, cy_ff;
   logic signed [32:0] cz_ff;
   logic [4:0] iter_ff;
   logic flip_ff, pass_ff;
   logic signed [31:0] sn_ff, cs_ff, hs_ff, hc_ff;
   logic signed [63:0] prod_ff;
   logic [1:0] step_ff;
   logic signed [31:0] wx_ff, wy_ff;
   logic signed [48:0] inc_ff;
   logic sign_ff;

   logic [55:0] mul_hi;
   logic [55:0] mul_lo;
   logic [31:0] ang_q;
   logic [31:0] cor_ang;
   logic signed [33:0] dx, dy;
   logic [31:0] arc;
   logic signed [33:0] fx, fy;
   logic signed [31:0] cl_x, cl_y;
   logic signed [31:0] op_a, op_b;
   logic signed [63:0] mul_out;
   logic signed [63:0] vsum;
   logic signed [33:0] vsh;
   logic signed [31:0] vsat;
   logic signed [31:0] w_sel;
   logic signed [48:0] pos_prod;
   logic signed [POS_BITS:0] pos_sum;
   logic signed [POS_BITS-1:0] pos_cur, pos_new;
   logic signed [48:0] inc_new;

   function automatic logic [47:0] req_yaw_rate_mag(input logic signed [31:0] w,
                                                     input logic [15:0] t);
      logic signed [48:0] p;
      begin
         p = 49'(w) * $signed({33'd0, t});
         return p[48] ? 48'(-p) : p[47:0];
      end
   endfunction

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (req_valid) state_in = ST_ANG_LO;
         ST_ANG_LO:    state_in = ST_ANG_HI;
         ST_ANG_HI:    state_in = ST_ANG_ADD;
         ST_ANG_ADD:   state_in = ST_COR_START;
         ST_COR_START: state_in = ST_COR_RUN;
         ST_COR_RUN:   if (iter_ff == 5'(CordicSteps-1)) state_in = ST_COR_DONE;
         ST_COR_DONE:  state_in = pass_ff ? ST_OUT : ST_MUL;
         ST_MUL:       state_in = ST_VEL;
         ST_VEL:       state_in = (step_ff == 2'd3) ? ST_POS_MUL : ST_MUL;
         ST_POS_MUL:   state_in = ST_POS_ADD;
         ST_POS_ADD:   state_in = (step_ff == 2'd1) ? ST_COR_START : ST_POS_MUL;
         ST_OUT:       if (!rsp_stall) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_OUT);
   end

   // angle step partial products: magnitude split at bit 24
   assign mul_hi = 56'(mag_ff[47:24]) * 56'(InvTwoPi);
   assign mul_lo = 56'(mag_ff[23:0]) * 56'(InvTwoPi);
   assign ang_q  = acc_ff[31:0];

   assign cor_ang = pass_ff ? {1'b0, heading_ff[31:1]} : heading_ff;
   assign arc = arc_lookup(iter_ff);
   assign dx = cy_ff >>> iter_ff;
   assign dy = cx_ff >>> iter_ff;
   assign fx = flip_ff ? -cx_ff : cx_ff;
   assign fy = flip_ff ? -cy_ff : cy_ff;
   assign cl_x = (fx > 34'sd1073741824) ? 32'sd1073741824 :
                 (fx < -34'sd1073741824) ? -32'sd1073741824 : 32'(fx);
   assign cl_y = (fy > 34'sd1073741824) ? 32'sd1073741824 :
                 (fy < -34'sd1073741824) ? -32'sd1073741824 : 32'(fy);

   // shared 32x32 multiplier
   always_comb begin
      unique case (step_ff)
         2'd0: begin op_a = vx_ff; op_b = cs_ff; end
         2'd1: begin op_a = vy_ff; op_b = sn_ff; end
         2'd2: begin op_a = vx_ff; op_b = sn_ff; end
         default: begin op_a = vy_ff; op_b = cs_ff; end
      endcase
   end
   assign mul_out = op_a * op_b;

   assign vsum = (step_ff == 2'd1) ? prod_ff - mul_out : prod_ff + mul_out;
   assign vsh  = 34'((vsum + 64'sd536870912) >>> 30);
   assign vsat = (vsh > 34'sd2147483647) ? 32'sh7FFFFFFF :
                 (vsh < -34'sd2147483648) ? 32'sh80000000 : 32'(vsh);

   // 32x17 product; the increment always fits in 32 bits signed
   assign w_sel    = step_ff[0] ? wy_ff : wx_ff;
   assign pos_prod = w_sel * $signed({1'b0, dt_ff});
   assign inc_new  = (pos_prod + 49'sd32768) >>> 16;
   assign pos_cur = step_ff[0] ? posy_ff : posx_ff;
   assign pos_sum = $signed({pos_cur[POS_BITS-1], pos_cur}) + (POS_BITS+1)'(inc_ff);
   always_comb begin
      if (pos_sum > $signed({1'b0, PosMax}))
         pos_new = PosMax;
      else if (pos_sum < $signed({1'b1, PosMin}))
         pos_new = PosMin;
      else
         pos_new = pos_sum[POS_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         heading_ff <= '0;
         posx_ff    <= '0;
         posy_ff    <= '0;
         iter_ff    <= '0;
         step_ff    <= '0;
         pass_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            ST_IDLE: if (req_valid) begin
               vx_ff  <= req_body_vel_x;
               vy_ff  <= req_body_vel_y;
               wz_ff  <= req_yaw_rate;
               dt_ff  <= req_elapsed_time;
               pass_ff <= 1'b0;
               step_ff <= '0;
            end
            ST_ANG_LO: begin
               prod_ff <= 64'(req_yaw_rate_mag(wz_ff, dt_ff));
               sign_ff <= wz_ff[31] && (dt_ff != 16'd0);
               mag_ff  <= req_yaw_rate_mag(wz_ff, dt_ff);
            end
            ST_ANG_HI: begin
               acc_ff <= 64'(mul_hi[55:8])
                  + 64'(({24'd0, mul_hi[7:0], 24'd0} + 64'(mul_lo) + 64'h80000000) >> 32);
            end
            ST_ANG_ADD:
               heading_ff <= heading_ff + (sign_ff ? (~ang_q + 32'd1) : ang_q);
            ST_COR_START: begin
               flip_ff <= (cor_ang[31:30] == 2'd1) || (cor_ang[31:30] == 2'd2);
               cz_ff   <= $signed({cor_ang[31] ^ ((cor_ang[31:30] == 2'd1)
                                  || (cor_ang[31:30] == 2'd2)),
                                  cor_ang[31] ^ ((cor_ang[31:30] == 2'd1)
                                  || (cor_ang[31:30] == 2'd2)), cor_ang[30:0]});
               cx_ff   <= CordicGain;
               cy_ff   <= '0;
               iter_ff <= '0;
            end
            ST_COR_RUN: begin
               if (!cz_ff[32]) begin
                  cx_ff <= cx_ff - dx;
                  cy_ff <= cy_ff + dy;
                  cz_ff <= cz_ff - $signed({1'b0, arc});
               end else begin
                  cx_ff <= cx_ff + dx;
                  cy_ff <= cy_ff - dy;
                  cz_ff <= cz_ff + $signed({1'b0, arc});
               end
               iter_ff <= iter_ff + 5'd1;
            end
            ST_COR_DONE: begin
               if (pass_ff) begin
                  hc_ff <= cl_x;
                  hs_ff <= cl_y;
               end else begin
                  cs_ff <= cl_x;
                  sn_ff <= cl_y;
               end
               step_ff <= '0;
            end
            ST_MUL: begin
               prod_ff <= mul_out;
               step_ff <= step_ff + 2'd1;
            end
            ST_VEL: begin
               if (step_ff == 2'd1) wx_ff <= vsat;
               else wy_ff <= vsat;
               if (step_ff == 2'd3) step_ff <= '0;
               else step_ff <= step_ff + 2'd1;
            end
            ST_POS_MUL: inc_ff <= inc_new;
            ST_POS_ADD: begin
               if (step_ff[0]) posy_ff <= pos_new;
               else posx_ff <= pos_new;
               step_ff <= step_ff + 2'd1;
               if (step_ff == 2'd1) pass_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   assign rsp_world_pos_x   = posx_ff;
   assign rsp_world_pos_y   = posy_ff;
   assign rsp_heading_angle = heading_ff;
   assign rsp_world_vel_x   = wx_ff;
   assign rsp_world_vel_y   = wy_ff;
   assign rsp_yaw_rate_out  = wz_ff;
   assign rsp_quat_z        = hs_ff;
   assign rsp_quat_w        = hc_ff;

endmodule

FILE: rtl/pho_checker.sv
// ----------------------------------------------------------------------------
// pho_checker
// port-level checks for the odometry block
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pho_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_heading_angle,
   input logic [31:0] rsp_quat_z
);
   `ASSERT_IMPL(a_busy_while_rsp, clock, reset, rsp_valid, req_stall,
      "accepting while result pending")
   `ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_heading_angle), "stalled result changed")
   `ASSERT_NEXT(a_accept_stalls, clock, reset, req_valid && !req_stall,
      req_stall && !rsp_valid, "no busy after accept")
   `ASSERT_IMPL(a_quat_z_range, clock, reset, rsp_valid,
      ($signed(rsp_quat_z) <= 32'sd1073741824) && ($signed(rsp_quat_z) >= -32'sd1073741824),
      "quat z out of range")
endmodule

bind planar_holonomic_odometry pho_checker u_pho_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_heading_angle(rsp_heading_angle), .rsp_quat_z(rsp_quat_z)
);
